[src/rld_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types and constants for the byte run-length decoder.
// ----------------------------------------------------------------------------
package rld_pkg;

   // Most copies one repeat byte can produce.
   localparam int MAX_RESULTS = 64;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam logic [7:0] COUNT_MASK  = 8'h7F;
   localparam logic [7:0] REPEAT_FLAG = 8'h80;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_LITERAL = 3'b010,
      PH_REPEAT  = 3'b100
   } phase_type;

   // One unit of output work: a byte and how many copies of it to send.
   typedef struct packed {
      logic [7:0]       data;
      logic [CNT_W-1:0] count;
   } job_type;

endpackage

[src/rld_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rld_decode
// Header/data parser. Tracks the stream phase and the run length, and turns
// each data byte into a job held in a one-entry job register.
// ----------------------------------------------------------------------------
module rld_decode #(
   parameter int MAX_RUN = 128
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [7:0]      req_in_byte,
   input  logic            req_final_byte,
   output logic            job_valid,
   output rld_pkg::job_type job,
   input  logic            job_take
);
   import rld_pkg::*;

   localparam int REM_W = $clog2(MAX_RUN + 1);

   phase_type        phase_ff, phase_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic             job_valid_ff, job_valid_in;
   job_type          job_ff, job_in;
   logic             new_job;
   logic             accept;
   logic [7:0]       hdr_count;
   logic [7:0]       rem8;
   logic [7:0]       rep_count;
   logic [REM_W-1:0] rem_dec;

   assign req_ready = !job_valid_ff || job_take;
   assign accept    = req_valid && req_ready;
   assign job_valid = job_valid_ff;
   assign job       = job_ff;

   always_comb begin
      hdr_count = (req_in_byte & COUNT_MASK) + 8'd1;
      if (hdr_count > 8'(MAX_RUN)) begin
         hdr_count = 8'(MAX_RUN);
      end
      rem8 = 8'(rem_ff);
      if (rem8 > 8'(MAX_RESULTS)) begin
         rep_count = 8'(MAX_RESULTS);
      end else if (rem8 == 8'd0) begin
         rep_count = 8'd1;
      end else begin
         rep_count = rem8;
      end
      rem_dec = (rem_ff != '0) ? rem_ff - REM_W'(1) : '0;
   end

   always_comb begin
      phase_in   = phase_ff;
      rem_in     = rem_ff;
      new_job    = 1'b0;
      job_in     = job_ff;
      case (phase_ff)
         PH_LITERAL: begin
            new_job      = 1'b1;
            job_in.data  = req_in_byte;
            job_in.count = CNT_W'(1);
            if (rem_dec == '0) begin
               phase_in = PH_HEADER;
               rem_in   = '0;
            end else begin
               rem_in = rem_dec;
            end
         end
         PH_REPEAT: begin
            new_job      = 1'b1;
            job_in.data  = req_in_byte;
            job_in.count = CNT_W'(rep_count);
            phase_in     = PH_HEADER;
            rem_in       = '0;
         end
         default: begin
            rem_in   = REM_W'(hdr_count);
            phase_in = ((req_in_byte & REPEAT_FLAG) != 8'd0) ? PH_REPEAT : PH_LITERAL;
         end
      endcase
      // final byte cuts short whatever run is open
      if (req_final_byte) begin
         phase_in = PH_HEADER;
         rem_in   = '0;
      end
   end

   always_comb begin
      if (accept) begin
         job_valid_in = new_job;
      end else if (job_take) begin
         job_valid_in = 1'b0;
      end else begin
         job_valid_in = job_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         rem_ff       <= '0;
         job_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
            rem_ff   <= rem_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && new_job) begin
         job_ff <= job_in;
      end
   end

   a_final_to_header: assert property (@(posedge clock) disable iff (reset)
      accept && req_final_byte |=> phase_ff == PH_HEADER && rem_ff == '0)
      else $error("final beat did not return decoder to header");

   a_header_rem_zero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEADER |-> rem_ff == '0)
      else $error("header phase with nonzero run length");

   a_job_holds: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && !job_take |=> job_valid_ff && $stable(job_ff))
      else $error("pending job lost or changed");

endmodule

[src/rld_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rld_emit
// Result register. Loads a job and sends its byte count times, marking the
// last copy.
// ----------------------------------------------------------------------------
module rld_emit (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  rld_pkg::job_type job,
   output logic             job_take,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_last
);
   import rld_pkg::*;

   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             last_copy;
   logic             out_beat;

   assign last_copy    = (left_ff == CNT_W'(1));
   assign out_beat     = valid_ff && rsp_ready;
   assign job_take     = job_valid && (!valid_ff || (out_beat && last_copy));
   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_run_last = last_copy;

   always_comb begin
      valid_in = valid_ff;
      left_in  = left_ff;
      if (job_take) begin
         valid_in = 1'b1;
         left_in  = job.count;
      end else if (out_beat) begin
         left_in = left_ff - CNT_W'(1);
         if (last_copy) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         left_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         left_ff  <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_take) begin
         byte_ff <= job.data;
      end
   end

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> left_ff != '0 && left_ff <= CNT_W'(MAX_RESULTS))
      else $error("copy count out of range");

   a_no_take_midrun: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !last_copy |-> !job_take)
      else $error("job loaded over an unfinished run");

   a_countdown: assert property (@(posedge clock) disable iff (reset)
      out_beat && !last_copy |=> valid_ff && left_ff == $past(left_ff) - CNT_W'(1))
      else $error("copy counter did not step down");

endmodule

[src/byte_rle_decoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_rle_decoder_core
// Run-length decoder for a byte stream with seven-bit counts.
// ----------------------------------------------------------------------------
// Takes one coded byte per beat. Header and literal bytes are accepted one per
// cycle while the job register has room; a literal byte gives one result beat
// via the job and result registers. A repeat byte with count n gives min(n, 64)
// result beats, one per cycle while rsp_ready is high, the last marked by
// rsp_run_last. While they go out the job register holds the next data byte, so
// input stalls after at most one more data beat (header bytes pass until then).
// A beat with req_final_byte set returns the parser to header state.
module byte_rle_decoder_core #(
   parameter int MAX_RUN = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);
   import rld_pkg::*;

   logic    job_valid;
   job_type job;
   logic    job_take;

   rld_decode #(
      .MAX_RUN (MAX_RUN)
   ) u_decode (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_final_byte (req_final_byte),
      .job_valid      (job_valid),
      .job            (job),
      .job_take       (job_take)
   );

   rld_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_valid),
      .job          (job),
      .job_take     (job_take),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

endmodule

[verif/byte_rle_decoder_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_rle_decoder_core_tb
// Self-checking bench for the byte run-length decoder.
// ----------------------------------------------------------------------------
// A directed table covers literal and repeat headers at both count extremes,
// the 64-copy cap, and final bytes on headers, mid-literal and on repeat data.
// Random streams of mostly well-formed runs with some noise follow. Every
// accepted coded byte runs through a local decoder model, and each result
// beat is compared against the oldest pending decoded byte. Both channels
// idle at random.
// ----------------------------------------------------------------------------
module byte_rle_decoder_core_tb;
   import rld_pkg::*;

   localparam int MAX_RUN      = 128;
   localparam int N_DIR        = 23;
   localparam int N_RAND       = 147;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 16;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_beat_type;

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
      logic       typed;   // n_copies below is the expected result count
      logic [6:0] n_copies;
   } stim_row_type;

   logic       clock;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte    = 8'h00;
   logic       req_final_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;

   // local copy of the decoder state
   phase_type  cur_phase = PH_HEADER;
   logic [7:0] run_left  = 8'd0;

   out_beat_type decoded_bytes [$];
   stim_row_type dir_tbl [N_DIR];
   int           err_count   = 0;
   int           beats_in    = 0;

   byte_rle_decoder_core #(
      .MAX_RUN(MAX_RUN)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .req_final_byte(req_final_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      err_count++;
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic stim_row_type row(input logic [7:0] data, input logic fin,
                                        input logic typed, input int n);
      row = {data, fin, typed, 7'(n)};
   endfunction

   task automatic go_header();
      cur_phase = PH_HEADER;
      run_left  = 8'd0;
   endtask

   // Advance the decoder model by one coded byte; optionally queue its results.
   task automatic decode_step(input logic [7:0] b, input logic fin, input bit keep);
      int cnt;
      int k;
      case (cur_phase)
         PH_LITERAL: begin
            if (keep) decoded_bytes.push_back({b, 1'b1});
            if (run_left != 0) run_left = run_left - 8'd1;
            if (run_left == 0) go_header();
         end
         PH_REPEAT: begin
            cnt = (run_left > MAX_RESULTS) ? MAX_RESULTS : int'(run_left);
            if (cnt == 0) cnt = 1;
            for (k = 0; k < cnt; k++)
               if (keep) decoded_bytes.push_back({b, (k == cnt - 1) ? 1'b1 : 1'b0});
            go_header();
         end
         default: begin
            cnt = int'(b & COUNT_MASK) + 1;
            if (cnt > MAX_RUN) cnt = MAX_RUN;
            run_left  = 8'(cnt);
            cur_phase = ((b & REPEAT_FLAG) != 0) ? PH_REPEAT : PH_LITERAL;
         end
      endcase
      if (fin) go_header();
   endtask

   // Drive one coded byte and hold it until accepted.
   task automatic send_beat(input logic [7:0] data, input logic fin,
                            input logic typed, input int n_typed);
      int k;
      req_valid      <= 1'b1;
      req_in_byte    <= data;
      req_final_byte <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (typed) begin
         for (k = 0; k < n_typed; k++)
            decoded_bytes.push_back({data, (k == n_typed - 1) ? 1'b1 : 1'b0});
         decode_step(data, fin, 1'b0);
      end else begin
         decode_step(data, fin, 1'b1);
      end
      beats_in++;
   endtask

   task automatic sender_gap(input bit steady);
      int n;
      n = steady ? 0 : gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (decoded_bytes.size() != 0) @(posedge clock);
   endtask

   // One random stream fragment: a run, broken run or noise byte.
   task automatic send_sequence();
      int  kind;
      int  cnt;
      int  k;
      bit  steady;
      logic fin;
      steady = ($urandom_range(0, 3) == 0);
      kind   = $urandom_range(0, 99);
      if (kind < 8) begin
         send_beat(8'($urandom), 1'($urandom_range(0, 1)), 1'b0, 0);
         sender_gap(steady);
      end else if (kind < 50) begin
         cnt = $urandom_range(0, 127);
         send_beat(REPEAT_FLAG | 8'(cnt), ($urandom_range(0, 15) == 0), 1'b0, 0);
         sender_gap(steady);
         send_beat(8'($urandom), ($urandom_range(0, 7) == 0), 1'b0, 0);
         sender_gap(steady);
      end else begin
         k = $urandom_range(0, 99);
         if (k < 80) cnt = $urandom_range(0, 7);
         else if (k < 97) cnt = $urandom_range(8, 31);
         else cnt = $urandom_range(32, 127);
         send_beat(8'(cnt), ($urandom_range(0, 15) == 0), 1'b0, 0);
         sender_gap(steady);
         // sometimes cut the run short so the next header lands as data
         if ($urandom_range(0, 9) == 0) cnt = $urandom_range(0, cnt);
         for (k = 0; k <= cnt; k++) begin
            fin = ($urandom_range(0, 31) == 0);
            send_beat(8'($urandom), fin, 1'b0, 0);
            sender_gap(steady);
            if (fin) break;
         end
      end
   endtask

   // result checker
   always @(posedge clock) begin : rsp_check
      out_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat byte=%02h last=%b",
                                      rsp_out_byte, rsp_run_last));
         end else begin
            want = decoded_bytes.pop_front();
            if (rsp_out_byte !== want.data)
               report_mismatch($sformatf("out_byte %02h, want %02h",
                                         rsp_out_byte, want.data));
            if (rsp_run_last !== want.last)
               report_mismatch($sformatf("run_last %b, want %b (byte %02h)",
                                         rsp_run_last, want.last, want.data));
         end
      end
   end

   // result-side backpressure
   initial begin : rsp_pacer
      int n;
      while (reset) @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 19) == 0) n = $urandom_range(100, 300);
         else n = $urandom_range(1, 24);
         repeat (n) @(posedge clock);
         n = gap_len();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   // stall watchdog: cycles with no beat on either channel
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
            idle = 0;
         else
            idle++;
      end
      $display("byte_rle_decoder_core verification failed");
      $finish;
   end

   initial begin : stimulus
      int  i;
      bit  paused;
      // after reset: header state
      dir_tbl[0]  = row(8'h00, 1'b0, 1'b1, 0);   // literal, count 1
      dir_tbl[1]  = row(8'hFF, 1'b0, 1'b1, 1);
      dir_tbl[2]  = row(8'h02, 1'b0, 1'b1, 0);   // literal, count 3
      dir_tbl[3]  = row(8'h00, 1'b0, 1'b1, 1);
      dir_tbl[4]  = row(8'hA5, 1'b1, 1'b1, 1);   // final cuts the literal run
      dir_tbl[5]  = row(8'hFF, 1'b0, 1'b1, 0);   // repeat 128 -> capped
      dir_tbl[6]  = row(8'h5A, 1'b0, 1'b1, 64);
      dir_tbl[7]  = row(8'h80, 1'b0, 1'b1, 0);   // repeat 1
      dir_tbl[8]  = row(8'h3C, 1'b0, 1'b1, 1);
      dir_tbl[9]  = row(8'h85, 1'b1, 1'b1, 0);   // final on a header
      dir_tbl[10] = row(8'h01, 1'b0, 1'b1, 0);   // literal, count 2
      dir_tbl[11] = row(8'h11, 1'b0, 1'b0, 0);
      dir_tbl[12] = row(8'h22, 1'b0, 1'b0, 0);
      dir_tbl[13] = row(8'hBF, 1'b0, 1'b1, 0);   // repeat 64, right at the cap
      dir_tbl[14] = row(8'h01, 1'b0, 1'b1, 64);
      dir_tbl[15] = row(8'hC0, 1'b0, 1'b1, 0);   // repeat 65, one over
      dir_tbl[16] = row(8'hFE, 1'b0, 1'b1, 64);
      dir_tbl[17] = row(8'h7F, 1'b0, 1'b1, 0);   // literal, count 128
      dir_tbl[18] = row(8'h10, 1'b0, 1'b0, 0);
      dir_tbl[19] = row(8'h20, 1'b1, 1'b1, 1);   // final mid literal run
      dir_tbl[20] = row(8'h83, 1'b0, 1'b0, 0);   // repeat 4
      dir_tbl[21] = row(8'hC3, 1'b1, 1'b0, 0);   // final on repeat data
      dir_tbl[22] = row(8'h00, 1'b1, 1'b1, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < N_DIR; i++) begin
         send_beat(dir_tbl[i].data, dir_tbl[i].fin, dir_tbl[i].typed,
                   int'(dir_tbl[i].n_copies));
         sender_gap(1'b0);
      end
      wait_drained();

      paused = 1'b0;
      while (beats_in < N_DIR + N_RAND) begin
         send_sequence();
         if (!paused && beats_in > N_DIR + N_RAND / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0 && decoded_bytes.size() == 0)
         $display("byte_rle_decoder_core verification clean");
      else
         $display("byte_rle_decoder_core verification failed");
      $finish;
   end

endmodule
